### hw/rtl/bba_pkg.sv
// Shared constants, types and helper functions of the bitmap block allocator.
package bba_pkg;

  localparam int IDX_W           = 17;
  localparam int NUM_BLOCKS      = 131072;
  localparam int RESERVED_BLOCKS = 13;
  localparam int WORD_W          = 32;
  localparam int BIT_W           = 5;
  localparam int WW              = IDX_W - BIT_W;
  localparam int SW              = WW - BIT_W;
  localparam int NB_W            = IDX_W + 1;

  function automatic int addr_w(int n);
    return (n <= 2) ? 1 : $clog2(n);
  endfunction

  localparam int L1_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int L2_WORDS  = (L1_WORDS + WORD_W - 1) / WORD_W;
  localparam int L3_CHUNKS = (L2_WORDS + WORD_W - 1) / WORD_W;
  localparam int L3_BITS   = L3_CHUNKS * WORD_W;
  localparam int L1_AW     = addr_w(L1_WORDS);
  localparam int L2_AW     = addr_w(L2_WORDS);
  localparam int L3_CW     = addr_w(L3_CHUNKS);
  localparam int L3_IW     = $clog2(L3_BITS);

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [NB_W-1:0]    nb_t;
  typedef logic [L3_BITS-1:0] l3_t;

  typedef struct packed {
    logic init_step;
    logic load_req;
    logic scan_step;
    logic find_step;
    logic free_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic chunk_zero;
    logic chunk_last;
    logic in_free;
    logic out_free;
  } status_t;

  function automatic logic [BIT_W-1:0] first_zero(word_t w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!w[b]) begin
        r = BIT_W'(b);
      end
    end
    return r;
  endfunction

  function automatic word_t init_l1(logic [WW-1:0] w);
    word_t r;
    nb_t   idx;
    r = '0;
    for (int b = 0; b < WORD_W; b++) begin
      idx  = {1'b0, w, BIT_W'(b)};
      r[b] = (idx < nb_t'(RESERVED_BLOCKS)) || (idx >= nb_t'(NUM_BLOCKS));
    end
    return r;
  endfunction

  function automatic word_t init_l2(logic [SW-1:0] s);
    word_t r;
    int    wi;
    r = '0;
    for (int j = 0; j < WORD_W; j++) begin
      wi   = int'({s, BIT_W'(j)});
      r[j] = (wi >= L1_WORDS) || (init_l1(WW'(wi)) == '1);
    end
    return r;
  endfunction

  function automatic l3_t init_l3();
    l3_t r;
    r = '0;
    for (int k = 0; k < L3_BITS; k++) begin
      r[k] = (k >= L2_WORDS) || (init_l2(SW'(k)) == '1);
    end
    return r;
  endfunction

  localparam l3_t L3_INIT = init_l3();

endpackage

### hw/rtl/bba_if.sv
// Request and result channel interfaces of the bitmap block allocator.
interface bba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [bba_pkg::IDX_W-1:0] block_index;
  modport source (output valid, output req_type, output block_index, input ready);
  modport sink (input valid, input req_type, input block_index, output ready);
endinterface

interface bba_res_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::IDX_W-1:0] alloc_index;
  logic                      full_res;
  modport source (output valid, output alloc_index, output full_res, input ready);
  modport sink (input valid, input alloc_index, input full_res, output ready);
endinterface

### hw/rtl/bitmap_block_allocator_core.sv
// Top level of the bitmap block allocator: controller, datapath and channel wiring.
//
// Usage: a request word on in_ch carries req_type (0 allocates the lowest free
// block, 1 frees block_index). Every request yields exactly one result word on
// out_ch: alloc_index holds the allocated block, and full_res is set when no
// block was free; both are zero for a free request.
// The usage bitmap lives in a 4096 x 32 RAM, summarized by a 128 x 32 RAM of
// full-word flags and a 128-bit register of full-summary flags.
// For an allocate, the top summary register is searched one 32-bit chunk per
// cycle (up to 4 chunks); if a chunk holds a free flag, one read of each RAM
// follows, then a commit step before the next ready. A free reads both RAMs
// once and then commits. The result word appears in the output register in
// the cycle after commit. After reset the block runs a clearing pass that
// writes every bitmap word, marking the 13 reserved blocks used; in_ch.ready
// stays low during this pass. A stalled receiver holds the result word in
// the output register; the next request is still accepted and worked on, and
// its commit waits until the pending result word has been taken.
module bitmap_block_allocator_core (
  input  logic      clk,
  input  logic      rst_n,
  bba_req_if.sink   in_ch,
  bba_res_if.source out_ch
);

  bba_pkg::cmd_t    cmd;
  bba_pkg::status_t status;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bba_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_ch.req_type),
    .in_block_index (in_ch.block_index),
    .cmd            (cmd),
    .status         (status),
    .out_ch         (out_ch)
  );

endmodule

### hw/rtl/bba_ram.sv
// Generic simple dual-port RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH <= 2) ? 1 : $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
module bba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bba_pkg::status_t status,
  output bba_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_FIND   = 6'b001000,
    ST_FREE   = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (status.init_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = status.in_free ? ST_FREE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.chunk_zero) begin
          state_nxt = ST_FIND;
        end else if (status.chunk_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_FIND: begin
        cmd.find_step = 1'b1;
        state_nxt     = ST_COMMIT;
      end
      ST_FREE: begin
        cmd.free_step = 1'b1;
        state_nxt     = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/bba_dpath.sv
// Datapath of the bitmap block allocator: three-level bitmap, scan logic and result register.
module bba_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_req_type,
  input  logic [bba_pkg::IDX_W-1:0] in_block_index,
  input  bba_pkg::cmd_t             cmd,
  output bba_pkg::status_t          status,
  bba_res_if.source                 out_ch
);

  logic [bba_pkg::L1_AW-1:0]  init_cnt_r;
  logic                       op_free_r;
  logic                       in_range_r;
  logic                       full_r;
  logic [bba_pkg::WW-1:0]     w_r;
  logic [bba_pkg::BIT_W-1:0]  b_r;
  logic [bba_pkg::SW-1:0]     s_r;
  logic [bba_pkg::L3_CW-1:0]  chunk_r;
  bba_pkg::l3_t               l3_r;
  logic                       out_valid_r;
  logic [bba_pkg::IDX_W-1:0]  out_alloc_index_r;
  logic                       out_full_res_r;

  bba_pkg::word_t             chunk_word;
  logic [bba_pkg::BIT_W-1:0]  chunk_fz;
  logic [bba_pkg::SW-1:0]     s_scan;
  logic [bba_pkg::SW-1:0]     w_s;
  logic [bba_pkg::WW-1:0]     w_find;
  logic                       chunk_last;

  logic                       l1_we, l1_re, l2_we, l2_re;
  logic [bba_pkg::L1_AW-1:0]  l1_waddr, l1_raddr;
  logic [bba_pkg::L2_AW-1:0]  l2_waddr, l2_raddr;
  bba_pkg::word_t             l1_wdata, l1_rdata, l2_wdata, l2_rdata;

  logic                       alloc_ok, free_ok, l1_now_full, init_l2_en;
  logic [bba_pkg::BIT_W-1:0]  bit_b;
  bba_pkg::word_t             bmask, jmask, l1_new, l2_new;

  assign chunk_word = l3_r[chunk_r*bba_pkg::WORD_W +: bba_pkg::WORD_W];
  assign chunk_fz   = bba_pkg::first_zero(chunk_word);
  assign s_scan     = bba_pkg::SW'({chunk_r, chunk_fz});
  assign chunk_last = (chunk_r == bba_pkg::L3_CW'(bba_pkg::L3_CHUNKS - 1));
  assign w_s        = w_r[bba_pkg::WW-1:bba_pkg::BIT_W];
  assign w_find     = {s_r, bba_pkg::first_zero(l2_rdata)};

  assign alloc_ok    = !op_free_r && !full_r;
  assign free_ok     = op_free_r && in_range_r;
  assign bit_b       = op_free_r ? b_r : bba_pkg::first_zero(l1_rdata);
  assign bmask       = bba_pkg::word_t'(1) << bit_b;
  assign jmask       = bba_pkg::word_t'(1) << w_r[bba_pkg::BIT_W-1:0];
  assign l1_new      = op_free_r ? (l1_rdata & ~bmask) : (l1_rdata | bmask);
  assign l2_new      = op_free_r ? (l2_rdata & ~jmask) : (l2_rdata | jmask);
  assign l1_now_full = (l1_new == '1);
  assign init_l2_en  = (init_cnt_r < bba_pkg::L1_AW'(bba_pkg::L2_WORDS));

  assign l1_re    = cmd.find_step || cmd.free_step;
  assign l1_raddr = cmd.find_step ? w_find[bba_pkg::L1_AW-1:0] : w_r[bba_pkg::L1_AW-1:0];
  assign l1_we    = cmd.init_step || (cmd.commit && (alloc_ok || free_ok));
  assign l1_waddr = cmd.init_step ? init_cnt_r : w_r[bba_pkg::L1_AW-1:0];
  assign l1_wdata = cmd.init_step ? bba_pkg::init_l1(bba_pkg::WW'(init_cnt_r)) : l1_new;

  assign l2_re    = (cmd.scan_step && status.chunk_zero) || cmd.free_step;
  assign l2_raddr = cmd.scan_step ? s_scan[bba_pkg::L2_AW-1:0] : w_s[bba_pkg::L2_AW-1:0];
  assign l2_we    = (cmd.init_step && init_l2_en) ||
                    (cmd.commit && (free_ok || (alloc_ok && l1_now_full)));
  assign l2_waddr = cmd.init_step ? init_cnt_r[bba_pkg::L2_AW-1:0] : w_s[bba_pkg::L2_AW-1:0];
  assign l2_wdata = cmd.init_step ? bba_pkg::init_l2(bba_pkg::SW'(init_cnt_r)) : l2_new;

  assign status.init_done  = (init_cnt_r == bba_pkg::L1_AW'(bba_pkg::L1_WORDS - 1));
  assign status.chunk_zero = (chunk_word != '1);
  assign status.chunk_last = chunk_last;
  assign status.in_free    = in_req_type;
  assign status.out_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.alloc_index = out_alloc_index_r;
  assign out_ch.full_res    = out_full_res_r;

  bba_ram #(.WIDTH(bba_pkg::WORD_W), .DEPTH(bba_pkg::L1_WORDS)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  bba_ram #(.WIDTH(bba_pkg::WORD_W), .DEPTH(bba_pkg::L2_WORDS)) u_l2_ram (
    .clk   (clk),
    .we    (l2_we),
    .waddr (l2_waddr),
    .wdata (l2_wdata),
    .re    (l2_re),
    .raddr (l2_raddr),
    .rdata (l2_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      l3_r        <= bba_pkg::L3_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_step && !status.init_done) begin
        init_cnt_r <= init_cnt_r + 1'b1;
      end
      if (cmd.commit && free_ok) begin
        l3_r[w_s[bba_pkg::L3_IW-1:0]] <= 1'b0;
      end else if (cmd.commit && alloc_ok && l1_now_full && (l2_new == '1)) begin
        l3_r[w_s[bba_pkg::L3_IW-1:0]] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_free_r  <= in_req_type;
      in_range_r <= ({1'b0, in_block_index} < bba_pkg::nb_t'(bba_pkg::NUM_BLOCKS));
      w_r        <= in_block_index[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
      b_r        <= in_block_index[bba_pkg::BIT_W-1:0];
      chunk_r    <= '0;
      full_r     <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (status.chunk_zero) begin
        s_r <= s_scan;
      end else if (chunk_last) begin
        full_r <= 1'b1;
      end else begin
        chunk_r <= chunk_r + 1'b1;
      end
    end
    if (cmd.find_step) begin
      w_r <= w_find;
    end
    if (cmd.commit) begin
      out_alloc_index_r <= alloc_ok ? {w_r, bit_b} : '0;
      out_full_res_r    <= full_r;
    end
  end

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ch.ready))
    else $error("Result word overwritten while still pending.");

  a_commit_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("Committed result word did not appear.");

  a_full_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_res_r) |-> (out_alloc_index_r == '0))
    else $error("Full result carries a nonzero block index.");

  a_no_alloc_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && alloc_ok) |=>
      ({1'b0, out_alloc_index_r} < bba_pkg::nb_t'(bba_pkg::NUM_BLOCKS)))
    else $error("Allocated block index lies past the end of the bitmap.");

endmodule
